### src/otot_pkg.sv
// ----------------------------------------------------------------------------
// One-shot timeout table package
// Shared widths, default sizes and item mode codes for the timeout table.
// ----------------------------------------------------------------------------
package otot_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int MODE_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 32;

   // Wide enough to hold any slot count in the supported range.
   localparam int SLOT_EXT_W = 7;

   localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RESTART  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CANCEL   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd3;

endpackage

### src/one_shot_timeout_table_core.sv
// ----------------------------------------------------------------------------
// One-shot timeout table core
// A table of one-shot timers against a wrapping tick counter. Start times
// and periods live in two synchronous memories; a tick scans the slots.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Ports                                    Handshake
//   req       in          req_mode, req_slot, req_period           valid/stall
//   rsp       out         rsp_expired_slot, rsp_expired_period,    valid/stall
//                         rsp_last
//
// Register, restart and cancel items complete in the idle state once taken.
// A tick starts the scan, reads each slot in turn from the start and period
// memories, and then hands over the final expiry.
// A stalled result port holds the scan only when a second expiry is found
// while the output register is still full, and the final hand-over waits
// until the output register is free.
// Reset is synchronous; it clears the time counter and all armed bits.
//
module one_shot_timeout_table_core
   import otot_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [PERIOD_W-1:0] req_period,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_expired_slot,
   output logic [PERIOD_W-1:0] rsp_expired_period,
   output logic                rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [SLOTS-1:0]    armed_ff, armed_in;
   logic [IW-1:0]       eval_ff, eval_in;

   logic                held_valid_ff, held_valid_in;
   logic [IW-1:0]       held_slot_ff, held_slot_in;
   logic [PERIOD_W-1:0] held_period_ff, held_period_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PERIOD_W-1:0] rsp_period_ff, rsp_period_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [TIME_W-1:0]   start_mem [SLOTS];
   logic [PERIOD_W-1:0] len_mem [SLOTS];
   logic [TIME_W-1:0]   start_rd_ff;
   logic [PERIOD_W-1:0] len_rd_ff;

   logic                rd_en;
   logic [IW-1:0]       rd_addr;
   logic                we_start;
   logic                we_len;

   logic                    req_take;
   logic [SLOT_EXT_W-1:0]   slot_ext;
   logic                    slot_ok;
   logic [IW-1:0]           slot_idx;
   logic [SLOT_EXT_W-1:0]   held_slot_ext;
   logic [TIME_W-1:0]       elapsed;
   logic                    hit;
   logic                    out_free;
   logic                    scan_block;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign slot_ext      = SLOT_EXT_W'(req_slot);
   assign slot_ok       = slot_ext < SLOT_EXT_W'(SLOTS);
   assign slot_idx      = slot_ext[IW-1:0];
   assign held_slot_ext = SLOT_EXT_W'(held_slot_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The read data belongs to slot eval_ff; the difference wraps modulo 2^32.
   assign elapsed    = now_ff - start_rd_ff;
   assign hit        = armed_ff[eval_ff] && (elapsed >= TIME_W'(len_rd_ff));
   // One expiry is held back so the last one of a tick can be flagged; a new
   // hit must push the held one out, which needs a free output register.
   assign scan_block = hit && held_valid_ff && !out_free;

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      armed_in       = armed_ff;
      eval_in        = eval_ff;
      held_valid_in  = held_valid_ff;
      held_slot_in   = held_slot_ff;
      held_period_in = held_period_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_slot_in    = rsp_slot_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      we_start       = 1'b0;
      we_len         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_mode == MODE_TICK) begin
                  now_in   = now_ff + TIME_W'(1);
                  eval_in  = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = ST_SCAN;
               end else if (slot_ok) begin
                  unique case (req_mode)
                     MODE_REGISTER: begin
                        armed_in[slot_idx] = 1'b1;
                        we_start           = 1'b1;
                        we_len             = 1'b1;
                     end
                     MODE_RESTART: begin
                        we_start = armed_ff[slot_idx];
                     end
                     default: begin
                        armed_in[slot_idx] = 1'b0;
                     end
                  endcase
               end
            end
         end
         ST_SCAN: begin
            if (!scan_block) begin
               if (hit) begin
                  armed_in[eval_ff] = 1'b0;
                  held_valid_in     = 1'b1;
                  held_slot_in      = eval_ff;
                  held_period_in    = len_rd_ff;
                  if (held_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_slot_in   = held_slot_ext[SLOT_W-1:0];
                     rsp_period_in = held_period_ff;
                     rsp_last_in   = 1'b0;
                  end
               end
               if (eval_ff == LAST_IDX) begin
                  state_in = ST_FLUSH;
               end else begin
                  eval_in = IW'(eval_ff + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = IW'(eval_ff + 1'b1);
               end
            end
         end
         ST_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = held_slot_ext[SLOT_W-1:0];
               rsp_period_in = held_period_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         armed_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         armed_ff      <= armed_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_ff        <= eval_in;
      held_slot_ff   <= held_slot_in;
      held_period_ff <= held_period_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (we_start) begin
         start_mem[slot_idx] <= now_ff;
      end
      if (we_len) begin
         len_mem[slot_idx] <= req_period;
      end
      if (rd_en) begin
         start_rd_ff <= start_mem[rd_addr];
         len_rd_ff   <= len_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_expired_slot   = rsp_slot_ff;
   assign rsp_expired_period = rsp_period_ff;
   assign rsp_last           = rsp_last_ff;

   // Results only come out of a tick scan or its final hand-over.
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SCAN || $past(state_ff) == ST_FLUSH))
      else $error("result appeared outside a tick scan");

   // No expiry may be left behind once the block is back to idle.
   a_no_held_in_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("held expiry left over after scan");

   // The hand-over at the end of a scan flags the final expiry of the tick.
   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && held_valid_ff && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final expiry of a tick not marked last");

   // A slot reported as expired is disarmed by the next cycle.
   a_hit_disarms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit && !scan_block) |=> !armed_ff[$past(eval_ff)])
      else $error("expired slot stayed armed");

endmodule

### dv/one_shot_timeout_table_core_tb.sv
// ----------------------------------------------------------------------------
// One-shot timeout table core testbench
// Drives register, restart, cancel and tick items into the core with random
// gaps and result stalls. A built-in model of the timer table predicts every
// expiry. Each reported expiry is checked in order against that prediction.
// A short table of directed items runs first, and a random mix follows.
// ----------------------------------------------------------------------------
module one_shot_timeout_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import otot_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SCAN_CYCLES  = SLOTS + 2;
   localparam int DIRECTED_N   = 25;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      logic                last;
   } expiry_type;

   // A row either leaves its results to the timer model or carries them typed in.
   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [SLOT_W-1:0]   slot;
      logic [PERIOD_W-1:0] period;
      bit                  typed;
      int                  typed_count;
      expiry_type          typed_expiry;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode = MODE_REGISTER;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [PERIOD_W-1:0] req_period = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SLOT_W-1:0]   rsp_expired_slot;
   logic [PERIOD_W-1:0] rsp_expired_period;
   logic                rsp_last;

   // Timer model state.
   logic [TIME_W-1:0]   tick_now;
   logic                slot_armed [SLOTS];
   logic [TIME_W-1:0]   slot_start [SLOTS];
   logic [PERIOD_W-1:0] slot_period [SLOTS];

   expiry_type       pending_expiries [$];
   directed_row_type directed_rows [DIRECTED_N];
   int               errors;
   int               cycle_count;
   bit               sender_calm;

   one_shot_timeout_table_core #(
      .SLOTS(SLOTS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_slot           (req_slot),
      .req_period         (req_period),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_expired_slot   (rsp_expired_slot),
      .rsp_expired_period (rsp_expired_period),
      .rsp_last           (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Applies one accepted item to the timer model. On a tick, every armed
   // slot whose elapsed time has reached its period expires in index order.
   task automatic advance_timers(input logic [MODE_W-1:0] mode,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [PERIOD_W-1:0] period,
                                 input bit record);
      expiry_type        found [$];
      logic [TIME_W-1:0] elapsed;
      if (mode == MODE_TICK) begin
         tick_now = tick_now + 1'b1;
         for (int i = 0; i < SLOTS; i++) begin
            elapsed = tick_now - slot_start[i];
            if (slot_armed[i] && elapsed >= TIME_W'(slot_period[i])) begin
               found.push_back('{slot: SLOT_W'(i), period: slot_period[i], last: 1'b0});
               slot_armed[i] = 1'b0;
            end
         end
         if (found.size() > 0) found[found.size() - 1].last = 1'b1;
         if (record) begin
            foreach (found[k]) pending_expiries.push_back(found[k]);
         end
      end else if (int'(slot) < SLOTS) begin
         case (mode)
            MODE_REGISTER: begin
               slot_armed[slot]  = 1'b1;
               slot_start[slot]  = tick_now;
               slot_period[slot] = period;
            end
            MODE_RESTART: begin
               if (slot_armed[slot]) slot_start[slot] = tick_now;
            end
            default: begin
               slot_armed[slot] = 1'b0;
            end
         endcase
      end
   endtask

   task automatic push_item(input logic [MODE_W-1:0] mode,
                            input logic [SLOT_W-1:0] slot,
                            input logic [PERIOD_W-1:0] period,
                            input bit record);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_slot   <= slot;
      req_period <= period;
      do @(posedge clock); while (req_stall);
      advance_timers(mode, slot, period, record);
   endtask

   task automatic check_expiry();
      expiry_type want;
      if (pending_expiries.size() == 0) begin
         $display("%0t: unexpected expiry, slot %0d period %0d last %0d", $time,
                  rsp_expired_slot, rsp_expired_period, rsp_last);
         errors++;
      end else begin
         want = pending_expiries.pop_front();
         if (rsp_expired_slot !== want.slot) begin
            $display("%0t: expired_slot expected %0d, got %0d", $time, want.slot,
                     rsp_expired_slot);
            errors++;
         end
         if (rsp_expired_period !== want.period) begin
            $display("%0t: expired_period expected %0d, got %0d", $time, want.period,
                     rsp_expired_period);
            errors++;
         end
         if (rsp_last !== want.last) begin
            $display("%0t: last expected %0d, got %0d", $time, want.last, rsp_last);
            errors++;
         end
      end
   endtask

   // Result side: checks each accepted result and stalls in random bursts,
   // with occasional long stretches of no stall at all.
   initial begin
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_expiry();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            if ($urandom_range(0, 9) == 0) free_left = $urandom_range(20, 80);
            else free_left = $urandom_range(0, 4);
            stall_left = pick_gap(1'b0);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("one_shot_timeout_table_core_tb: FAIL");
      $finish;
   end

   initial begin
      int                  items;
      int                  r;
      bit                  burst_zero;
      logic [PERIOD_W-1:0] period;
      errors      = 0;
      sender_calm = 1'b0;
      tick_now    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_armed[i]  = 1'b0;
         slot_start[i]  = '0;
         slot_period[i] = '0;
      end

      directed_rows = '{
         // Tick straight after reset: nothing is armed.
         '{MODE_TICK,     4'd0,  16'd0,      1'b1, 0, '{4'd0, 16'd0, 1'b0}},
         // Restart and cancel of empty slots do nothing.
         '{MODE_RESTART,  4'd3,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_CANCEL,   4'd4,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         // A zero period expires on the very next tick.
         '{MODE_REGISTER, 4'd0,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd0,  16'd0,      1'b1, 1, '{4'd0, 16'd0, 1'b1}},
         '{MODE_REGISTER, 4'd15, 16'hFFFF,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         // Re-register overwrites the period of slot 5.
         '{MODE_REGISTER, 4'd5,  16'd2,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd5,  16'd1,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd9,  16'd1,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd7,  16'h1234,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         // Restart pushes the expiry of slot 2 out by one tick.
         '{MODE_REGISTER, 4'd2,  16'd3,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd0,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_RESTART,  4'd2,  16'hFFFF,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd0,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd0,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd15, 16'hFFFF,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd7,  16'h5555,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd8,  16'hAAAA,   1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_CANCEL,   4'd7,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_CANCEL,   4'd8,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_CANCEL,   4'd15, 16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         // Everything cancelled: a tick reports nothing.
         '{MODE_TICK,     4'd0,  16'd0,      1'b1, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd1,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_REGISTER, 4'd14, 16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}},
         '{MODE_TICK,     4'd0,  16'd0,      1'b0, 0, '{4'd0, 16'd0, 1'b0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         push_item(directed_rows[n].mode, directed_rows[n].slot, directed_rows[n].period,
                   !directed_rows[n].typed);
         if (directed_rows[n].typed) begin
            for (int k = 0; k < directed_rows[n].typed_count; k++)
               pending_expiries.push_back(directed_rows[n].typed_expiry);
         end
      end

      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 49) == 0) sender_calm = ~sender_calm;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            // Arm every slot with a short period, so that one tick can
            // report the whole table.
            burst_zero = $urandom_range(0, 1);
            for (int s = 0; s < SLOTS; s++) begin
               if (burst_zero) period = '0;
               else period = PERIOD_W'($urandom_range(0, 2));
               push_item(MODE_REGISTER, SLOT_W'(s), period, 1'b1);
            end
            items += SLOTS;
         end else begin
            if (r < 35) begin
               if ($urandom_range(0, 9) == 0) period = PERIOD_W'($urandom);
               else period = PERIOD_W'($urandom_range(0, 12));
               push_item(MODE_REGISTER, SLOT_W'($urandom), period, 1'b1);
            end else if (r < 50) begin
               push_item(MODE_RESTART, SLOT_W'($urandom), PERIOD_W'($urandom), 1'b1);
            end else if (r < 60) begin
               push_item(MODE_CANCEL, SLOT_W'($urandom), PERIOD_W'($urandom), 1'b1);
            end else begin
               push_item(MODE_TICK, SLOT_W'($urandom), PERIOD_W'($urandom), 1'b1);
            end
            items++;
         end
      end
      req_valid <= 1'b0;

      while (pending_expiries.size() != 0) @(posedge clock);
      repeat (2 * SCAN_CYCLES) @(posedge clock);

      if (errors == 0) $display("one_shot_timeout_table_core_tb: PASS");
      else $display("one_shot_timeout_table_core_tb: FAIL");
      $finish;
   end

endmodule
